// ===== src/qacf_pkg.sv =====
package qacf_pkg;

   // Longest text line the counter is sized for
   localparam longint unsigned MAX_TEXT_LEN = 64'd65536;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned OFFSET_W = 16;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 2;

   // Byte address of comment_char
   localparam logic [CSR_ADDR_W-1:0] CSR_COMMENT_CHAR_ADDR = '0;

   // Position counter saturates at min(MAX_TEXT_LEN-1, 2^OFFSET_W-1)
   localparam longint unsigned OFFSET_MAX = (64'd1 << OFFSET_W) - 64'd1;
   localparam logic [OFFSET_W-1:0] POS_CAP =
      OFFSET_W'(((MAX_TEXT_LEN - 64'd1) > OFFSET_MAX) ? OFFSET_MAX : (MAX_TEXT_LEN - 64'd1));

   // Special bytes
   localparam logic [BYTE_W-1:0] CHAR_DQUOTE    = 8'h22;
   localparam logic [BYTE_W-1:0] CHAR_SQUOTE    = 8'h27;
   localparam logic [BYTE_W-1:0] CHAR_SLASH     = 8'h2F;
   localparam logic [BYTE_W-1:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [BYTE_W-1:0] CHAR_OPEN_D2   = 8'hD2;
   localparam logic [BYTE_W-1:0] CHAR_CLOSE_D3  = 8'hD3;

   // Result payload handed from the scanner to the output register
   typedef struct packed {
      logic                found;
      logic [OFFSET_W-1:0] offset;
   } scan_result_type;

endpackage

// ===== src/qacf_if.sv =====
interface qacf_req_if;
   import qacf_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] text_byte;
   logic              last_byte;

   modport source (output valid, output text_byte, output last_byte, input ready);
   modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

interface qacf_rsp_if;
   import qacf_pkg::*;
   logic                valid;
   logic                ready;
   logic                found;
   logic [OFFSET_W-1:0] offset;

   modport source (output valid, output found, output offset, input ready);
   modport sink   (input valid, input found, input offset, output ready);
endinterface

// ===== src/qacf_csr.sv =====
module qacf_csr
   import qacf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [BYTE_W-1:0]     comment_char
);

   logic [BYTE_W-1:0] comment_char_ff;
   logic [BYTE_W-1:0] comment_char_in;
   logic              wr_en;

   // Single register at byte address 0
   assign wr_en = csr_psel & csr_penable & csr_pwrite & csr_pready &
                  (csr_paddr == CSR_COMMENT_CHAR_ADDR);

   always_comb begin
      comment_char_in = comment_char_ff;
      if (wr_en) begin
         comment_char_in = csr_pwdata[BYTE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         comment_char_ff <= '0;
      end else begin
         comment_char_ff <= comment_char_in;
      end
   end

   assign csr_prdata   = {{(CSR_DATA_W-BYTE_W){1'b0}}, comment_char_ff};
   assign csr_pready   = 1'b1;
   assign comment_char = comment_char_ff;

endmodule

// ===== src/qacf_scan.sv =====
module qacf_scan
   import qacf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   qacf_req_if.sink          req_ch,
   input  logic [BYTE_W-1:0] comment_char,
   input  logic              out_free,
   output logic              res_valid,
   output scan_result_type   res
);

   // Input register
   logic              s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0] s1_byte_ff, s1_byte_in;
   logic              s1_last_ff, s1_last_in;

   // Line state
   logic                in_quote_ff, in_quote_in;
   logic                in_escape_ff, in_escape_in;
   logic [BYTE_W-1:0]   close_ff, close_in;
   logic                pend_slash_ff, pend_slash_in;
   logic [OFFSET_W-1:0] pos_ff, pos_in;
   logic                done_ff, done_in;

   logic                s1_fire;
   logic                req_fire;
   logic                hit;
   logic [OFFSET_W-1:0] hit_off;

   assign s1_fire      = s1_valid_ff & out_free;
   assign req_ch.ready = ~s1_valid_ff | out_free;
   assign req_fire     = req_ch.valid & req_ch.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      s1_last_in  = s1_last_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
         s1_byte_in  = req_ch.text_byte;
         s1_last_in  = req_ch.last_byte;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   // Scan one byte
   always_comb begin
      hit           = 1'b0;
      hit_off       = '0;
      in_quote_in   = in_quote_ff;
      in_escape_in  = in_escape_ff;
      close_in      = close_ff;
      pend_slash_in = pend_slash_ff;

      if (!done_ff) begin
         if (pend_slash_ff && s1_byte_ff == CHAR_SLASH) begin
            hit     = 1'b1;
            hit_off = (pos_ff != '0) ? pos_ff - OFFSET_W'(1) : '0;
         end else begin
            pend_slash_in = 1'b0;
            if (in_quote_ff) begin
               if (in_escape_ff) begin
                  in_escape_in = 1'b0;
               end else if (s1_byte_ff == CHAR_BACKSLASH) begin
                  in_escape_in = 1'b1;
               end else if (s1_byte_ff == close_ff) begin
                  in_quote_in = 1'b0;
               end
            end else if (s1_byte_ff == CHAR_DQUOTE) begin
               in_quote_in = 1'b1;
               close_in    = CHAR_DQUOTE;
            end else if (s1_byte_ff == CHAR_OPEN_D2) begin
               in_quote_in = 1'b1;
               close_in    = CHAR_CLOSE_D3;
            end else if (s1_byte_ff == CHAR_SQUOTE) begin
               in_quote_in = 1'b1;
               close_in    = CHAR_SQUOTE;
            end else if (s1_byte_ff == comment_char) begin
               hit     = 1'b1;
               hit_off = pos_ff;
            end else if (s1_byte_ff == CHAR_SLASH) begin
               pend_slash_in = 1'b1;
            end
         end
      end

      done_in = done_ff | hit;
      pos_in  = (pos_ff < POS_CAP) ? pos_ff + OFFSET_W'(1) : pos_ff;

      if (s1_last_ff) begin
         in_quote_in   = 1'b0;
         in_escape_in  = 1'b0;
         close_in      = '0;
         pend_slash_in = 1'b0;
         pos_in        = '0;
         done_in       = 1'b0;
      end
   end

   assign res_valid  = s1_fire & ~done_ff & (hit | s1_last_ff);
   assign res.found  = hit;
   assign res.offset = hit_off;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         in_quote_ff   <= 1'b0;
         in_escape_ff  <= 1'b0;
         close_ff      <= '0;
         pend_slash_ff <= 1'b0;
         pos_ff        <= '0;
         done_ff       <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (s1_fire) begin
            in_quote_ff   <= in_quote_in;
            in_escape_ff  <= in_escape_in;
            close_ff      <= close_in;
            pend_slash_ff <= pend_slash_in;
            pos_ff        <= pos_in;
            done_ff       <= done_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_byte_ff <= s1_byte_in;
      s1_last_ff <= s1_last_in;
   end

endmodule

// ===== src/qacf_out.sv =====
module qacf_out
   import qacf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            res_valid,
   input  scan_result_type res,
   output logic            out_free,
   qacf_rsp_if.source      rsp_ch
);

   logic            valid_ff, valid_in;
   scan_result_type data_ff, data_in;

   assign out_free = ~valid_ff | rsp_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (res_valid) begin
         valid_in = 1'b1;
         data_in  = res;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_ch.valid  = valid_ff;
   assign rsp_ch.found  = data_ff.found;
   assign rsp_ch.offset = data_ff.offset;

endmodule

// ===== src/quote_aware_comment_finder.sv =====
// Channel  Dir  Handshake      Payload
// req_ch   in   valid/ready    text_byte[7:0], last_byte
// rsp_ch   out  valid/ready    found, offset[15:0]
// csr_*    in   APB write/read comment_char at byte address 0
//
// One byte per cycle sustained while rsp_ch is not back-pressuring; a result
// passes through the input register, then the result register, before it leaves.
// Reset is synchronous and active high; it clears line state and comment_char.
// A stalled result holds in the result register while the next byte waits in
// the input register; req_ch.ready drops only when both are full.
module quote_aware_comment_finder
   import qacf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   qacf_req_if.sink              req_ch,
   qacf_rsp_if.source            rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [BYTE_W-1:0] comment_char;
   logic              out_free;
   logic              res_valid;
   scan_result_type   res;

   // Delimiter register
   qacf_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .comment_char (comment_char)
   );

   // Input register plus quote/escape/slash tracking; one byte per transaction
   qacf_scan u_scan (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .comment_char (comment_char),
      .out_free     (out_free),
      .res_valid    (res_valid),
      .res          (res)
   );

   // Result register; at most one result per line
   qacf_out u_out (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .out_free  (out_free),
      .rsp_ch    (rsp_ch)
   );

endmodule

// ===== sim/tb_quote_aware_comment_finder.sv =====
`timescale 1ns / 100ps

module tb_quote_aware_comment_finder;
   import qacf_pkg::*;

   // CSR map: comment_char is register 0, byte address 0
   localparam logic [CSR_ADDR_W-1:0] COMMENT_CHAR_ADDR = CSR_ADDR_W'(0);

   // Cycles with no transaction on either channel before the run is called hung
   localparam int unsigned STALL_LIMIT = 2000;

   // Minimum random bytes per comment_char setting (whole lines are sent)
   localparam int unsigned PHASE_BYTES = 90;

   // Printable filler
   localparam logic [BYTE_W-1:0] CHAR_FILL = 8'h61;   // 'a'
   localparam logic [BYTE_W-1:0] CHAR_HASH = 8'h23;   // '#'
   localparam logic [BYTE_W-1:0] CHAR_SEMI = 8'h3B;   // ';'
   localparam logic [BYTE_W-1:0] CHAR_X    = 8'h78;   // 'x'

   // -----------------------------------------------------------------------
   // Line scanner predictor + expected result store
   // -----------------------------------------------------------------------
   class comment_scoreboard;
      logic [BYTE_W-1:0]   delim;
      bit                  in_str;
      bit                  escaped;
      logic [BYTE_W-1:0]   closer;
      bit                  slash_seen;
      logic [OFFSET_W-1:0] pos;
      bit                  line_done;
      scan_result_type     expected_q[$];
      int unsigned         errors;

      function new();
         delim  = '0;
         errors = 0;
         clear_line();
      endfunction

      function void clear_line();
         in_str     = 1'b0;
         escaped    = 1'b0;
         closer     = '0;
         slash_seen = 1'b0;
         pos        = '0;
         line_done  = 1'b0;
      endfunction

      function void set_delim(logic [BYTE_W-1:0] value);
         delim = value;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void report(string msg);
         $display("%0t ERROR: %s", $time, msg);
         errors++;
      endfunction

      // Accepted input transaction: advance the line state, queue any result
      function void note_byte(logic [BYTE_W-1:0] b, bit is_last);
         bit                  hit;
         logic [OFFSET_W-1:0] hit_off;
         hit     = 1'b0;
         hit_off = '0;
         if (!line_done) begin
            if (slash_seen && b == CHAR_SLASH) begin
               // second slash reports the first one's offset
               hit     = 1'b1;
               hit_off = (pos != 0) ? pos - 1'b1 : '0;
            end else begin
               slash_seen = 1'b0;
               if (in_str) begin
                  if (escaped)
                     escaped = 1'b0;
                  else if (b == CHAR_BACKSLASH)
                     escaped = 1'b1;
                  else if (b == closer)
                     in_str = 1'b0;
               end else if (b == CHAR_DQUOTE) begin
                  in_str = 1'b1;
                  closer = CHAR_DQUOTE;
               end else if (b == CHAR_OPEN_D2) begin
                  in_str = 1'b1;
                  closer = CHAR_CLOSE_D3;
               end else if (b == CHAR_SQUOTE) begin
                  in_str = 1'b1;
                  closer = CHAR_SQUOTE;
               end else if (b == delim) begin
                  // delimiter test precedes the slash test
                  hit     = 1'b1;
                  hit_off = pos;
               end else if (b == CHAR_SLASH) begin
                  slash_seen = 1'b1;
               end
            end
            if (hit) begin
               expected_q.push_back(scan_result_type'{found: 1'b1, offset: hit_off});
               line_done = 1'b1;
            end else if (is_last) begin
               expected_q.push_back(scan_result_type'{found: 1'b0, offset: '0});
            end
         end
         if (pos < POS_CAP)
            pos++;
         if (is_last)
            clear_line();
      endfunction

      // Accepted result transaction: compare with the oldest expectation
      function void check_result(logic found, logic [OFFSET_W-1:0] offset);
         scan_result_type exp_res;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected result found=%0b offset=%0d", found, offset));
            return;
         end
         exp_res = expected_q.pop_front();
         if (found !== exp_res.found)
            report($sformatf("found: got %0b exp %0b", found, exp_res.found));
         if (offset !== exp_res.offset)
            report($sformatf("offset: got %0d exp %0d", offset, exp_res.offset));
      endfunction
   endclass

   // -----------------------------------------------------------------------
   // Clock, reset, DUT
   // -----------------------------------------------------------------------
   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   qacf_req_if req_if();
   qacf_rsp_if rsp_if();

   comment_scoreboard sb = new();

   bit                idle_on;        // random bubbles / stalls enabled
   int unsigned       bytes_sent;
   int unsigned       quiet_cycles;
   logic [BYTE_W-1:0] line_buf[$];

   always begin
      clock <= 1'b0;
      #5;
      clock <= 1'b1;
      #5;
   end

   quote_aware_comment_finder uut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // -----------------------------------------------------------------------
   // Monitor + watchdog. Everything sampled here is pre-edge, since the
   // DUT and the drivers only change signals through NBAs at the edge.
   // -----------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready)
         sb.note_byte(req_if.text_byte, req_if.last_byte);
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_result(rsp_if.found, rsp_if.offset);

      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
         $display("Regression FAIL");
         $finish;
      end
   end

   // Result sink: random back-pressure bursts while idle_on
   initial begin : rsp_backpressure
      int unsigned stall_left;
      stall_left   = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_if.ready <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_if.ready <= 1'b0;
            stall_left = $urandom_range(1, 5) - 1;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // -----------------------------------------------------------------------
   // Drivers
   // -----------------------------------------------------------------------

   // One input transaction, optionally preceded by a bubble burst.
   // Valid stays high back to back unless a bubble is inserted.
   task automatic send_byte(input logic [BYTE_W-1:0] b, input bit is_last);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.text_byte <= b;
      req_if.last_byte <= is_last;
      do @(posedge clock); while (!req_if.ready);
      bytes_sent++;
   endtask

   task automatic send_line();
      foreach (line_buf[i])
         send_byte(line_buf[i], i == line_buf.size() - 1);
      line_buf.delete();
   endtask

   // Stop sending and wait until every queued result has come back,
   // then let the two-stage pipe empty.
   task automatic drain_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic csr_read(input logic [CSR_ADDR_W-1:0] addr,
                           output logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      data = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Change the delimiter with the block idle; junk in the upper bits
   // must be dropped, readback must match.
   task automatic set_comment_char(input logic [BYTE_W-1:0] value);
      logic [CSR_DATA_W-1:0] rd;
      drain_results();
      csr_write(COMMENT_CHAR_ADDR, {(CSR_DATA_W-BYTE_W)'($urandom), value});
      sb.set_delim(value);
      csr_read(COMMENT_CHAR_ADDR, rd);
      if (rd[BYTE_W-1:0] !== value)
         sb.report($sformatf("comment_char readback %02h exp %02h", rd[BYTE_W-1:0], value));
   endtask

   // Byte mix biased toward the characters the scanner reacts to
   function automatic logic [BYTE_W-1:0] pick_byte(input logic [BYTE_W-1:0] delim);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 30)      return BYTE_W'($urandom_range(8'h61, 8'h7A));
      else if (r < 38) return 8'h20;
      else if (r < 46) return CHAR_DQUOTE;
      else if (r < 51) return CHAR_SQUOTE;
      else if (r < 55) return CHAR_OPEN_D2;
      else if (r < 59) return CHAR_CLOSE_D3;
      else if (r < 66) return CHAR_BACKSLASH;
      else if (r < 78) return CHAR_SLASH;
      else if (r < 84) return delim;
      else             return BYTE_W'($urandom);
   endfunction

   // Random lines, mostly short, now and then a longer one
   task automatic run_random_lines(input int unsigned count);
      int unsigned target;
      int unsigned len;
      target = bytes_sent + count;
      while (bytes_sent < target) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 16);
         repeat (len) line_buf.push_back(pick_byte(sb.delim));
         send_line();
      end
   endtask

   // -----------------------------------------------------------------------
   // Test sequence
   // -----------------------------------------------------------------------
   initial begin : main_seq
      logic [BYTE_W-1:0] phase_delim[8];

      reset            = 1'b1;
      idle_on          = 1'b1;
      bytes_sent       = 0;
      quiet_cycles     = 0;
      req_if.valid     = 1'b0;
      req_if.text_byte = '0;
      req_if.last_byte = 1'b0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed, delimiter at its reset value 0x00 ---
      // NUL byte is the delimiter itself
      line_buf = {8'h00};
      send_line();
      // double slash reports the first slash; trailing byte ignored
      line_buf = {CHAR_FILL, CHAR_SLASH, CHAR_SLASH, CHAR_X};
      send_line();
      // escaped quote and NUL inside a string; lone slash on the last byte
      line_buf = {CHAR_DQUOTE, CHAR_BACKSLASH, CHAR_DQUOTE, 8'h00, CHAR_DQUOTE, CHAR_SLASH};
      send_line();
      // D2..D3 string holding a dquote, then single-quoted NUL, ends on 0xFF
      line_buf = {CHAR_OPEN_D2, CHAR_DQUOTE, CHAR_CLOSE_D3, CHAR_SQUOTE, 8'h00,
                  CHAR_SQUOTE, 8'hFF};
      send_line();

      // delimiter is slash: a single slash hits at its own offset
      set_comment_char(CHAR_SLASH);
      line_buf = {CHAR_X, CHAR_SLASH, CHAR_SLASH};
      send_line();
      line_buf = {CHAR_DQUOTE, CHAR_SLASH, CHAR_DQUOTE};
      send_line();

      // --- random phases, each with its own delimiter ---
      phase_delim[0] = 8'h00;
      phase_delim[1] = 8'hFF;
      phase_delim[2] = CHAR_SLASH;
      phase_delim[3] = CHAR_BACKSLASH;
      phase_delim[4] = CHAR_HASH;
      phase_delim[5] = BYTE_W'($urandom);
      phase_delim[6] = BYTE_W'($urandom);
      phase_delim[7] = CHAR_SEMI;

      foreach (phase_delim[p]) begin
         set_comment_char(phase_delim[p]);
         if (p == 7)
            idle_on = 1'b0;   // last stretch runs at full rate
         run_random_lines(PHASE_BYTES);
      end

      // --- wind down ---
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (6) @(posedge clock);

      if (sb.errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/qacf_pkg.sv
src/qacf_if.sv
src/qacf_csr.sv
src/qacf_scan.sv
src/qacf_out.sv
src/quote_aware_comment_finder.sv
sim/tb_quote_aware_comment_finder.sv
